// ----- rtl/npb_pkg.sv -----
// ----------------------------------------------------------------------------
// npb_pkg
// Shared constants, codes and transfer types of the nibble-packed blitter.
// ----------------------------------------------------------------------------
package npb_pkg;

    localparam int ROW_WORDS   = 12;
    localparam int STORE_ROWS  = 32;
    localparam int STORE_WORDS = ROW_WORDS * STORE_ROWS;

    localparam int WORD_W      = 16;
    localparam int FUNC_W      = 2;
    localparam int HOST_ADDR_W = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 6;

    localparam int WIDTH_W     = 6;
    localparam int HEIGHT_W    = 6;
    localparam int XPOS_W      = 6;
    localparam int YPOS_W      = 5;
    localparam int CARRY_W     = 12;
    localparam int SRC_W       = WORD_W + CARRY_W;
    localparam int ROW_W       = HEIGHT_W;
    localparam int K_W         = $clog2(((1 << WIDTH_W) - 1) / 4 + 3);

    localparam int WIDTH_RST   = 48;
    localparam int HEIGHT_RST  = 1;

    localparam int NUM_BANKS   = 2;
    localparam int BANK_DEPTH  = (STORE_WORDS + 1) / 2;
    localparam int IDX_W       = $clog2(BANK_DEPTH);

    localparam int ADDR_SPAN   = ((1 << YPOS_W) + (1 << HEIGHT_W)) * ROW_WORDS + 64;
    localparam int ADDR_W_GEO  = $clog2(ADDR_SPAN);
    localparam int ADDR_W_MIN  = (IDX_W > HOST_ADDR_W) ? IDX_W + 1 : HOST_ADDR_W + 1;
    localparam int ADDR_W      = (ADDR_W_GEO > ADDR_W_MIN) ? ADDR_W_GEO : ADDR_W_MIN;

    localparam int OUTQ_DEPTH  = 3;
    localparam int OUTQ_PTR_W  = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W  = $clog2(OUTQ_DEPTH + 1);

    typedef enum logic [FUNC_W-1:0] {
        FN_WRITE  = 2'd0,
        FN_READ   = 2'd1,
        FN_SOURCE = 2'd2,
        FN_START  = 2'd3
    } npb_func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_XPOS   = 2'd2,
        CFG_YPOS   = 2'd3
    } npb_cfg_idx_t;

    typedef struct packed {
        logic              en;
        logic              wr;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] mask;
        logic [WORD_W-1:0] val;
    } npb_bank_op_t;

    typedef struct packed {
        logic                         valid;
        logic                         rd_result;
        logic                         rd_ok;
        logic                         done_result;
        logic                         rd_bank;
        npb_bank_op_t [NUM_BANKS-1:0] bank;
    } npb_req_t;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] read_data;
        logic              done;
    } npb_rsp_t;

endpackage

// ----- rtl/nibble_packed_blit.sv -----
// ----------------------------------------------------------------------------
// nibble_packed_blit
// Blitter for 4-bit pixels packed four to a word into a 12-word-per-row store.
//
//   channel  handshake             payload
//   req      req_valid / req_stall func, word_addr, word_data
//   rsp      rsp_valid / rsp_stall read_data, blit_done
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// one item per cycle while req_stall is low; each item reads the store when accepted and writes back
// the cycle after, the even/odd word banks serving a word and its neighbour
// results pass the write-back register and then the result queue before leaving the rsp channel
// reset clears control and sets the configuration to its defaults; the store has no clearing pass
// req_stall rises when the three-entry result queue plus the item in
// write-back could fill
// ----------------------------------------------------------------------------
module nibble_packed_blit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic [npb_pkg::FUNC_W-1:0]      func,
    input  logic [npb_pkg::HOST_ADDR_W-1:0] word_addr,
    input  logic [npb_pkg::WORD_W-1:0]      word_data,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic [npb_pkg::WORD_W-1:0]      read_data,
    output logic                            blit_done,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [npb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [npb_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import npb_pkg::*;

    npb_req_t                req;
    npb_rsp_t                wb_rsp;
    logic [OUTQ_CNT_W-1:0]   q_count;
    logic                    req_accept;

    assign req_stall  = (({1'b0, q_count} + (OUTQ_CNT_W + 1)'(wb_rsp.valid))
                         >= (OUTQ_CNT_W + 1)'(OUTQ_DEPTH));
    assign req_accept = req_valid && !req_stall;

    npb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_accept (req_accept),
        .func       (func),
        .word_addr  (word_addr),
        .word_data  (word_data),
        .req        (req)
    );

    npb_mem u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (wb_rsp)
    );

    npb_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_item (wb_rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .read_data (read_data),
        .blit_done (blit_done),
        .count     (q_count)
    );

endmodule

// ----- rtl/npb_ram.sv -----
// ----------------------------------------------------------------------------
// npb_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module npb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/npb_ctrl.sv -----
// ----------------------------------------------------------------------------
// npb_ctrl
// Configuration registers, blit sequencer and store request generation.
// Each accepted item becomes one request for the even and odd store banks.
// ----------------------------------------------------------------------------
module npb_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [npb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [npb_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           req_accept,
    input  logic [npb_pkg::FUNC_W-1:0]     func,
    input  logic [npb_pkg::HOST_ADDR_W-1:0] word_addr,
    input  logic [npb_pkg::WORD_W-1:0]     word_data,
    output npb_pkg::npb_req_t              req
);

    import npb_pkg::*;

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [XPOS_W-1:0]   xpos_reg;
    logic [YPOS_W-1:0]   ypos_reg;

    logic                active_reg,      active_next;
    logic [ROW_W-1:0]    row_reg,         row_next;
    logic [K_W-1:0]      k_reg,           k_next;
    logic [CARRY_W-1:0]  carry_reg,       carry_next;
    logic [ADDR_W-1:0]   base_reg,        base_next;
    logic [HEIGHT_W-1:0] lat_height_reg,  lat_height_next;
    logic [1:0]          lat_shift_reg,   lat_shift_next;
    logic [WORD_W-1:0]   lat_first_reg,   lat_first_next;
    logic [WORD_W-1:0]   lat_keep_reg,    lat_keep_next;
    logic [K_W-1:0]      lat_last_reg,    lat_last_next;
    logic [K_W-1:0]      lat_count_reg,   lat_count_next;

    logic [1:0]          geo_r;
    logic [1:0]          geo_s;
    logic [K_W-1:0]      geo_n;
    logic [K_W-1:0]      geo_n2;
    logic [K_W-1:0]      geo_last;
    logic [K_W-1:0]      geo_count;
    logic [WORD_W-1:0]   geo_tail;
    logic [2*WORD_W-1:0] geo_wide;
    logic                geo_fits;
    logic [WORD_W-1:0]   geo_keep;
    logic [WORD_W-1:0]   geo_first;
    logic [ADDR_W-1:0]   geo_base;

    npb_func_t           func_code;
    logic [SRC_W-1:0]    src_wide;
    logic [WORD_W-1:0]   src_lo;
    logic [CARRY_W-1:0]  src_spill;
    logic [CARRY_W-1:0]  carry_step;
    logic                k_first;
    logic                k_at_last;
    logic                k_pre_last;
    logic                row_end;
    logic                blit_end;

    logic [ADDR_W-1:0]   x_addr;
    logic [ADDR_W-1:0]   y_addr;
    logic                x_ok;
    logic                y_ok;
    logic                x_act;
    logic                x_wr;
    logic [WORD_W-1:0]   x_mask;
    logic [WORD_W-1:0]   x_val;
    logic                y_act;
    logic [WORD_W-1:0]   y_mask;
    logic [WORD_W-1:0]   y_val;
    logic                rd_result;
    logic                done_result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_W'(WIDTH_RST);
            height_reg <= HEIGHT_W'(HEIGHT_RST);
            xpos_reg   <= '0;
            ypos_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (npb_cfg_idx_t'(cfg_index))
                CFG_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                CFG_XPOS:   xpos_reg   <= cfg_data[XPOS_W-1:0];
                CFG_YPOS:   ypos_reg   <= cfg_data[YPOS_W-1:0];
            endcase
        end
    end

    // row geometry, latched at start
    always_comb
    begin
        geo_r     = width_reg[1:0];
        geo_s     = xpos_reg[1:0];
        geo_n     = K_W'(width_reg[WIDTH_W-1:2]) + K_W'(geo_r != 2'd0);
        geo_tail  = (geo_r == 2'd0) ? '0 : WORD_W'({WORD_W{1'b1}} << {geo_r, 2'b00});
        geo_wide  = {{WORD_W{1'b1}}, geo_tail} << {geo_s, 2'b00};
        geo_fits  = (geo_wide[2*WORD_W-1:WORD_W] == {WORD_W{1'b1}});
        geo_keep  = geo_fits ? geo_wide[WORD_W-1:0] : geo_wide[2*WORD_W-1:WORD_W];
        geo_first = ~(WORD_W'({WORD_W{1'b1}} << {geo_s, 2'b00}));
        geo_n2    = geo_n + K_W'(!geo_fits);
        geo_last  = (geo_n2 >= K_W'(2)) ? geo_n2 - K_W'(1) : K_W'(1);
        geo_count = geo_fits ? geo_last + K_W'(1) : geo_last;
        geo_base  = ADDR_W'(xpos_reg[XPOS_W-1:2])
                  + ADDR_W'(ypos_reg) * ADDR_W'(ROW_WORDS);
    end

    // source word position within the row
    always_comb
    begin
        func_code  = npb_func_t'(func);
        src_wide   = SRC_W'(word_data) << {lat_shift_reg, 2'b00};
        src_lo     = src_wide[WORD_W-1:0];
        src_spill  = src_wide[SRC_W-1:WORD_W];
        k_first    = (k_reg == '0);
        k_at_last  = (k_reg >= lat_last_reg);
        k_pre_last = ((k_reg + K_W'(1)) == lat_last_reg);
        row_end    = ((k_reg + K_W'(1)) >= lat_count_reg);
        blit_end   = row_end
                   && (({1'b0, row_reg} + (ROW_W + 1)'(1)) >= {1'b0, lat_height_reg});
        carry_step = k_at_last ? carry_reg : src_spill;
        if (func_code == FN_SOURCE)
        begin
            x_addr = base_reg + ADDR_W'(k_at_last ? lat_last_reg : k_reg);
        end
        else
        begin
            x_addr = ADDR_W'(word_addr);
        end
        y_addr = x_addr + ADDR_W'(1);
        x_ok   = (x_addr < ADDR_W'(STORE_WORDS));
        y_ok   = (y_addr < ADDR_W'(STORE_WORDS));
    end

    // store operations of the item
    always_comb
    begin
        x_act       = 1'b0;
        x_wr        = 1'b0;
        x_mask      = '0;
        x_val       = '0;
        y_act       = 1'b0;
        y_mask      = lat_keep_reg;
        y_val       = WORD_W'(carry_step);
        rd_result   = 1'b0;
        done_result = 1'b0;
        unique case (func_code)
            FN_WRITE:
            begin
                x_act = 1'b1;
                x_wr  = 1'b1;
                x_val = word_data;
            end
            FN_READ:
            begin
                x_act     = 1'b1;
                rd_result = 1'b1;
            end
            FN_SOURCE:
            begin
                if (active_reg)
                begin
                    x_act = 1'b1;
                    x_wr  = 1'b1;
                    if (k_first)
                    begin
                        x_mask = lat_first_reg;
                        x_val  = src_lo;
                    end
                    else if (!k_at_last)
                    begin
                        x_mask = '0;
                        x_val  = WORD_W'(carry_reg) | src_lo;
                    end
                    else
                    begin
                        x_mask = '1;
                        x_val  = src_lo;
                    end
                    y_act       = k_pre_last;
                    done_result = blit_end;
                end
            end
            FN_START:
            begin
            end
        endcase
    end

    always_comb
    begin
        req             = '0;
        req.valid       = req_accept;
        req.rd_result   = req_accept && rd_result;
        req.rd_ok       = x_ok;
        req.done_result = req_accept && done_result;
        req.rd_bank     = x_addr[0];
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            if (x_addr[0] == 1'(b))
            begin
                req.bank[b].en   = req_accept && x_act && x_ok;
                req.bank[b].wr   = x_wr;
                req.bank[b].idx  = x_addr[IDX_W:1];
                req.bank[b].mask = x_mask;
                req.bank[b].val  = x_val;
            end
            else
            begin
                req.bank[b].en   = req_accept && y_act && y_ok;
                req.bank[b].wr   = 1'b1;
                req.bank[b].idx  = y_addr[IDX_W:1];
                req.bank[b].mask = y_mask;
                req.bank[b].val  = y_val;
            end
        end
    end

    always_comb
    begin
        active_next     = active_reg;
        row_next        = row_reg;
        k_next          = k_reg;
        carry_next      = carry_reg;
        base_next       = base_reg;
        lat_height_next = lat_height_reg;
        lat_shift_next  = lat_shift_reg;
        lat_first_next  = lat_first_reg;
        lat_keep_next   = lat_keep_reg;
        lat_last_next   = lat_last_reg;
        lat_count_next  = lat_count_reg;
        if (req_accept)
        begin
            if (func_code == FN_SOURCE && active_reg)
            begin
                if (row_end)
                begin
                    k_next     = '0;
                    carry_next = '0;
                    row_next   = row_reg + ROW_W'(1);
                    base_next  = base_reg + ADDR_W'(ROW_WORDS);
                    if (blit_end)
                    begin
                        active_next = 1'b0;
                    end
                end
                else
                begin
                    k_next     = k_reg + K_W'(1);
                    carry_next = carry_step;
                end
            end
            else if (func_code == FN_START)
            begin
                active_next     = (height_reg != '0);
                row_next        = '0;
                k_next          = '0;
                carry_next      = '0;
                base_next       = geo_base;
                lat_height_next = height_reg;
                lat_shift_next  = geo_s;
                lat_first_next  = geo_first;
                lat_keep_next   = geo_keep;
                lat_last_next   = geo_last;
                lat_count_next  = geo_count;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            row_reg        <= '0;
            k_reg          <= '0;
            carry_reg      <= '0;
            base_reg       <= '0;
            lat_height_reg <= '0;
            lat_shift_reg  <= '0;
            lat_first_reg  <= '0;
            lat_keep_reg   <= '0;
            lat_last_reg   <= '0;
            lat_count_reg  <= '0;
        end
        else
        begin
            active_reg     <= active_next;
            row_reg        <= row_next;
            k_reg          <= k_next;
            carry_reg      <= carry_next;
            base_reg       <= base_next;
            lat_height_reg <= lat_height_next;
            lat_shift_reg  <= lat_shift_next;
            lat_first_reg  <= lat_first_next;
            lat_keep_reg   <= lat_keep_next;
            lat_last_reg   <= lat_last_next;
            lat_count_reg  <= lat_count_next;
        end
    end

    a_k_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (k_reg < lat_count_reg))
        else $error("word position past end of row");

    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (k_reg == '0 && carry_reg == '0))
        else $error("row state left behind while idle");

endmodule

// ----- rtl/npb_mem.sv -----
// ----------------------------------------------------------------------------
// npb_mem
// Destination store as even and odd word banks, with the write-back stage.
// Reads are issued with the request, merged in the cycle after and written back;
// a write-back to the word being read in the same cycle is forwarded.
// ----------------------------------------------------------------------------
module npb_mem (
    input  logic              clk,
    input  logic              rst_n,
    input  npb_pkg::npb_req_t req,
    output npb_pkg::npb_rsp_t rsp
);

    import npb_pkg::*;

    npb_req_t              s1_reg;
    logic [NUM_BANKS-1:0]  byp_valid_reg;
    logic [NUM_BANKS-1:0]  byp_valid_next;
    logic [WORD_W-1:0]     byp_data_reg [NUM_BANKS];
    logic [WORD_W-1:0]     ram_q        [NUM_BANKS];
    logic [WORD_W-1:0]     bank_q       [NUM_BANKS];
    logic [WORD_W-1:0]     bank_new     [NUM_BANKS];
    logic [NUM_BANKS-1:0]  bank_we;

    for (genvar g = 0; g < NUM_BANKS; g++)
    begin : g_bank
        npb_ram #(
            .WIDTH (WORD_W),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .clk   (clk),
            .we    (bank_we[g]),
            .waddr (s1_reg.bank[g].idx),
            .wdata (bank_new[g]),
            .re    (req.bank[g].en),
            .raddr (req.bank[g].idx),
            .rdata (ram_q[g])
        );
    end

    always_comb
    begin
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            bank_q[b]         = byp_valid_reg[b] ? byp_data_reg[b] : ram_q[b];
            bank_new[b]       = (bank_q[b] & s1_reg.bank[b].mask) | s1_reg.bank[b].val;
            bank_we[b]        = s1_reg.valid && s1_reg.bank[b].en && s1_reg.bank[b].wr;
            byp_valid_next[b] = req.bank[b].en && bank_we[b]
                              && (req.bank[b].idx == s1_reg.bank[b].idx);
        end
    end

    always_comb
    begin
        rsp.valid     = s1_reg.valid && (s1_reg.rd_result || s1_reg.done_result);
        rsp.read_data = (s1_reg.rd_result && s1_reg.rd_ok) ? bank_q[s1_reg.rd_bank] : '0;
        rsp.done      = s1_reg.done_result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg        <= '0;
            byp_valid_reg <= '0;
        end
        else
        begin
            s1_reg        <= req;
            byp_valid_reg <= byp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            byp_data_reg[b] <= bank_new[b];
        end
    end

    a_read_one_bank: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_reg.valid && s1_reg.rd_result) |-> !s1_reg.bank[~s1_reg.rd_bank].en)
        else $error("host read touches both banks");

endmodule

// ----- rtl/npb_outq.sv -----
// ----------------------------------------------------------------------------
// npb_outq
// Three-entry result queue between the write-back stage and the rsp channel.
// ----------------------------------------------------------------------------
module npb_outq (
    input  logic                           clk,
    input  logic                           rst_n,
    input  npb_pkg::npb_rsp_t              push_item,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic [npb_pkg::WORD_W-1:0]     read_data,
    output logic                           blit_done,
    output logic [npb_pkg::OUTQ_CNT_W-1:0] count
);

    import npb_pkg::*;

    logic [WORD_W:0]         entry_reg [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0]   head_reg, head_next;
    logic [OUTQ_PTR_W-1:0]   tail_reg, tail_next;
    logic [OUTQ_CNT_W-1:0]   cnt_reg,  cnt_next;
    logic                    push;
    logic                    pop;

    always_comb
    begin
        push      = push_item.valid;
        pop       = (cnt_reg != '0) && !rsp_stall;
        head_next = head_reg;
        tail_next = tail_reg;
        if (pop)
        begin
            head_next = (head_reg == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0
                      : head_reg + OUTQ_PTR_W'(1);
        end
        if (push)
        begin
            tail_next = (tail_reg == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0
                      : tail_reg + OUTQ_PTR_W'(1);
        end
        cnt_next = cnt_reg + OUTQ_CNT_W'(push) - OUTQ_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[tail_reg] <= {push_item.read_data, push_item.done};
        end
    end

    assign rsp_valid = (cnt_reg != '0);
    assign read_data = entry_reg[head_reg][WORD_W:1];
    assign blit_done = entry_reg[head_reg][0];
    assign count     = cnt_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (cnt_reg < OUTQ_CNT_W'(OUTQ_DEPTH)))
        else $error("result queue overflow");

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the nibble-packed blitter. The store is preloaded
// through the host port, then a directed table and a long random run of
// blits, host reads and writes and stray items are sent with random idling
// on both channels. A predictor in the bench follows the store and the blit
// walk, and every read-back and end-of-blit transfer is compared in order.
// ----------------------------------------------------------------------------
module tb;
    import npb_pkg::*;

    localparam int RANDOM_ITEMS = 1240;
    localparam int SETTLE       = 6;

    typedef struct packed {
        logic [WORD_W-1:0] rd;
        logic              done;
    } readout_t;

    typedef struct packed {
        bit                    cfg;
        npb_cfg_idx_t          reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        npb_func_t             op;
        logic [HOST_ADDR_W-1:0] addr;
        logic [WORD_W-1:0]     data;
        bit                    typed;
        logic [WORD_W-1:0]     want_rd;
        bit                    want_done;
    } step_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_stall;
    logic [FUNC_W-1:0]      func = FN_WRITE;
    logic [HOST_ADDR_W-1:0] word_addr = '0;
    logic [WORD_W-1:0]      word_data = '0;
    logic                   rsp_valid;
    logic                   rsp_stall = 1'b0;
    logic [WORD_W-1:0]      read_data;
    logic                   blit_done;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = CFG_WIDTH;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // predictor state
    logic [WORD_W-1:0] pix_store [0:STORE_WORDS-1];
    int unsigned       cur_row = 0;
    int unsigned       cur_word = 0;
    logic [WORD_W-1:0] spill_carry = '0;
    bit                blit_on = 1'b0;
    logic [5:0]        cfg_w = 6'(WIDTH_RST);
    logic [5:0]        cfg_h = 6'(HEIGHT_RST);
    logic [5:0]        cfg_x = '0;
    logic [4:0]        cfg_y = '0;
    int unsigned       geo_h = 0;
    int unsigned       geo_shift = 0;
    int unsigned       geo_xw = 0;
    int unsigned       geo_y = 0;
    int unsigned       geo_last = 0;
    logic [WORD_W-1:0] geo_first = '0;
    logic [WORD_W-1:0] geo_keep = '0;
    bit                geo_fits = 1'b0;

    readout_t    expected_readouts [$];
    int          mismatches = 0;
    int unsigned items_sent = 0;
    int unsigned results_seen = 0;
    int unsigned blits_seen = 0;
    int unsigned cfg_writes = 0;
    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned stall_left = 0;

    step_t steps [40] = '{
        '{1'b0, CFG_WIDTH,  6'd0,  FN_WRITE,  9'd0,   16'hffff, 1'b0, 16'h0000, 1'b0},
        '{1'b0, CFG_WIDTH,  6'd0,  FN_READ,   9'd0,   16'h0000, 1'b1, 16'hffff, 1'b0},
        '{1'b0, CFG_WIDTH,  6'd0,  FN_WRITE,  9'd383, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{1'b0, CFG_WIDTH,  6'd0,  FN_READ,   9'd383, 16'hffff, 1'b1, 16'h0000, 1'b0},
        '{1'b0, CFG_WIDTH,  6'd0,  FN_WRITE,  9'd511, 16'h1234, 1'b0, 16'h0000, 1'b0},
        '{1'b0, CFG_WIDTH,  6'd0,  FN_READ,   9'd511, 16'h0000, 1'b1, 16'h0000, 1'b0},
        '{1'b0, CFG_WIDTH,  6'd0,  FN_SOURCE, 9'd0,   16'hffff, 1'b0, 16'h0000, 1'b0},
        '{1'b1, CFG_WIDTH,  6'd5,  FN_WRITE,  9'd0,   16'h0000, 1'b0, 16'h0000, 1'b0},
        '{1'b1, CFG_HEIGHT, 6'd2,  FN_WRITE,  9'd0,   16'h0000, 1'b0, 16'h0000, 1'b0},
        '{1'b1, CFG_XPOS,   6'd3,  FN_WRITE,  9'd0,   16'h0000, 1'b0, 16'h0000, 1'b0},
        '{1'b1, CFG_YPOS,   6'd31, FN_WRITE,  9'd0,   16'h0000, 1'b0, 16'h0000, 1'b0},
        '{1'b0, CFG_WIDTH,  6'd0,  FN_START,  9'd0,   16'h0000, 1'b0, 16'h0000, 1'b0},
        '{1'b0, CFG_WIDTH,  6'd0,  FN_SOURCE, 9'd0,   16'h1234, 1'b0, 16'h0000, 1'b0},
        '{1'b0, CFG_WIDTH,  6'd0,  FN_SOURCE, 9'd0,   16'hfedc, 1'b0, 16'h0000, 1'b0},
        '{1'b0, CFG_WIDTH,  6'd0,  FN_SOURCE, 9'd0,   16'h0f0f, 1'b0, 16'h0000, 1'b0},
        '{1'b0, CFG_WIDTH,  6'd0,  FN_SOURCE, 9'd0,   16'hffff, 1'b1, 16'h0000, 1'b1},
        '{1'b0, CFG_WIDTH,  6'd0,  FN_READ,   9'd372, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{1'b1, CFG_WIDTH,  6'd3,  FN_WRITE,  9'd0,   16'h0000, 1'b0, 16'h0000, 1'b0},
        '{1'b1, CFG_HEIGHT, 6'd1,  FN_WRITE,  9'd0,   16'h0000, 1'b0, 16'h0000, 1'b0},
        '{1'b1, CFG_XPOS,   6'd2,  FN_WRITE,  9'd0,   16'h0000, 1'b0, 16'h0000, 1'b0},
        '{1'b1, CFG_YPOS,   6'd0,  FN_WRITE,  9'd0,   16'h0000, 1'b0, 16'h0000, 1'b0},
        '{1'b0, CFG_WIDTH,  6'd0,  FN_START,  9'd0,   16'h0000, 1'b0, 16'h0000, 1'b0},
        '{1'b0, CFG_WIDTH,  6'd0,  FN_SOURCE, 9'd0,   16'habcd, 1'b1, 16'h0000, 1'b1},
        '{1'b0, CFG_WIDTH,  6'd0,  FN_READ,   9'd1,   16'h0000, 1'b0, 16'h0000, 1'b0},
        '{1'b1, CFG_WIDTH,  6'd1,  FN_WRITE,  9'd0,   16'h0000, 1'b0, 16'h0000, 1'b0},
        '{1'b1, CFG_XPOS,   6'd0,  FN_WRITE,  9'd0,   16'h0000, 1'b0, 16'h0000, 1'b0},
        '{1'b0, CFG_WIDTH,  6'd0,  FN_START,  9'd0,   16'h0000, 1'b0, 16'h0000, 1'b0},
        '{1'b0, CFG_WIDTH,  6'd0,  FN_SOURCE, 9'd0,   16'h0001, 1'b0, 16'h0000, 1'b0},
        '{1'b0, CFG_WIDTH,  6'd0,  FN_SOURCE, 9'd0,   16'h0000, 1'b1, 16'h0000, 1'b1},
        '{1'b1, CFG_HEIGHT, 6'd0,  FN_WRITE,  9'd0,   16'h0000, 1'b0, 16'h0000, 1'b0},
        '{1'b0, CFG_WIDTH,  6'd0,  FN_START,  9'd0,   16'h0000, 1'b0, 16'h0000, 1'b0},
        '{1'b0, CFG_WIDTH,  6'd0,  FN_SOURCE, 9'd0,   16'h5555, 1'b0, 16'h0000, 1'b0},
        '{1'b1, CFG_HEIGHT, 6'd1,  FN_WRITE,  9'd0,   16'h0000, 1'b0, 16'h0000, 1'b0},
        '{1'b1, CFG_XPOS,   6'd45, FN_WRITE,  9'd0,   16'h0000, 1'b0, 16'h0000, 1'b0},
        '{1'b0, CFG_WIDTH,  6'd0,  FN_START,  9'd0,   16'h0000, 1'b0, 16'h0000, 1'b0},
        '{1'b0, CFG_WIDTH,  6'd0,  FN_SOURCE, 9'd0,   16'h8888, 1'b0, 16'h0000, 1'b0},
        '{1'b0, CFG_WIDTH,  6'd0,  FN_START,  9'd0,   16'h0000, 1'b0, 16'h0000, 1'b0},
        '{1'b0, CFG_WIDTH,  6'd0,  FN_SOURCE, 9'd0,   16'h1111, 1'b0, 16'h0000, 1'b0},
        '{1'b0, CFG_WIDTH,  6'd0,  FN_SOURCE, 9'd0,   16'h2222, 1'b1, 16'h0000, 1'b1},
        '{1'b0, CFG_WIDTH,  6'd0,  FN_READ,   9'd12,  16'h0000, 1'b0, 16'h0000, 1'b0}
    };

    nibble_packed_blit dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("FAIL nibble_packed_blit");
        $finish;
    end

    function automatic logic [WORD_W-1:0] peek(input int unsigned a);
        return (a < STORE_WORDS) ? pix_store[a] : '0;
    endfunction

    function automatic void poke(input int unsigned a, input logic [WORD_W-1:0] v);
        if (a < STORE_WORDS)
            pix_store[a] = v;
    endfunction

    function automatic void latch_geometry();
        int unsigned r, s, n, last_m, spill, first, i;
        r = cfg_w & 3;
        s = cfg_x & 3;
        n = (cfg_w >> 2) + ((r != 0) ? 1 : 0);
        last_m = (r != 0) ? (32'hffff << (4 * r)) : 0;
        spill = 32'hffff;
        first = 0;
        for (i = 0; i < s; i++)
        begin
            first = (first << 4) | 32'hf;
            spill = (spill << 4) | ((last_m & 32'hf000) >> 12);
            last_m = last_m << 4;
        end
        geo_fits = ((spill & 32'hffff) == 32'hffff);
        geo_keep = geo_fits ? last_m[15:0] : spill[15:0];
        if (!geo_fits)
            n++;
        geo_last = (n >= 2) ? n - 1 : 1;
        geo_first = first[15:0];
        geo_shift = s;
        geo_xw = cfg_x >> 2;
        geo_y = cfg_y;
        geo_h = cfg_h;
        cur_row = 0;
        cur_word = 0;
        spill_carry = '0;
        blit_on = (cfg_h != 0);
    endfunction

    // one source word of the running blit; true when it closes the blit
    function automatic bit sink_source_word(input logic [WORD_W-1:0] d);
        int unsigned       wide, base, k, cnt;
        logic [WORD_W-1:0] lo, sp;
        wide = {16'h0, d};
        wide = wide << (4 * geo_shift);
        lo = wide[15:0];
        sp = {4'h0, wide[27:16]};
        base = geo_xw + (geo_y + cur_row) * ROW_WORDS;
        k = cur_word;
        cnt = geo_fits ? geo_last + 1 : geo_last;
        if (k == 0)
        begin
            poke(base, (peek(base) & geo_first) | lo);
            spill_carry = sp;
        end
        else if (k < geo_last)
        begin
            poke(base + k, spill_carry | lo);
            spill_carry = sp;
        end
        else
            poke(base + geo_last, peek(base + geo_last) | lo);
        if (k + 1 == geo_last)
            poke(base + geo_last, (peek(base + geo_last) & geo_keep) | spill_carry);
        if (k + 1 >= cnt)
        begin
            cur_word = 0;
            spill_carry = '0;
            cur_row++;
            if (cur_row >= geo_h)
            begin
                blit_on = 1'b0;
                return 1'b1;
            end
        end
        else
            cur_word++;
        return 1'b0;
    endfunction

    function automatic bit predict_item(input npb_func_t op, input logic [HOST_ADDR_W-1:0] addr,
                                        input logic [WORD_W-1:0] data, output readout_t res,
                                        output bit skip);
        res = '0;
        skip = 1'b0;
        case (op)
            FN_WRITE:
            begin
                poke(addr, data);
                return 1'b0;
            end
            FN_READ:
            begin
                res.rd = peek(addr);
                return 1'b1;
            end
            FN_SOURCE:
            begin
                if (!blit_on)
                begin
                    skip = 1'b1;
                    return 1'b0;
                end
                res.done = sink_source_word(data);
                return res.done;
            end
            default:
            begin
                latch_geometry();
                return 1'b0;
            end
        endcase
    endfunction

    function automatic int unsigned blit_words();
        return blit_on ? geo_h * (geo_fits ? geo_last + 1 : geo_last) : 0;
    endfunction

    task automatic send_item(input npb_func_t op, input logic [HOST_ADDR_W-1:0] addr,
                             input logic [WORD_W-1:0] data, input bit typed = 1'b0,
                             input logic [WORD_W-1:0] want_rd = '0, input bit want_done = 1'b0);
        readout_t    res;
        bit          has, skip;
        int unsigned gap;
        @(negedge clk);
        if ($urandom_range(0, 99) < gap_pct)
        begin
            gap = $urandom_range(1, 15);
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        func <= op;
        word_addr <= addr;
        word_data <= data;
        do @(posedge clk); while (req_stall);
        has = predict_item(op, addr, data, res, skip);
        if (typed)
        begin
            res.rd = want_rd;
            res.done = want_done;
            has = 1'b1;
        end
        if (has)
            expected_readouts.push_back(res);
        if (!skip)
            items_sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        req_valid <= 1'b0;
        while (expected_readouts.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_cfg(input npb_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_WIDTH:  cfg_w = val;
            CFG_HEIGHT: cfg_h = val;
            CFG_XPOS:   cfg_x = val;
            default:    cfg_y = val[4:0];
        endcase
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic choose_setting();
        logic [5:0] w, h, x, y;
        case ($urandom_range(0, 9))
            0:       h = 6'd0;
            1:       h = 6'($urandom_range(5, 63));
            default: h = 6'($urandom_range(1, 4));
        endcase
        if (h > 4)
            w = 6'($urandom_range(0, 8));
        else if ($urandom_range(0, 3) == 0)
            case ($urandom_range(0, 4))
                0:       w = 6'd0;
                1:       w = 6'd1;
                2:       w = 6'd47;
                3:       w = 6'd48;
                default: w = 6'd63;
            endcase
        else
            w = 6'($urandom_range(0, 63));
        if ($urandom_range(0, 3) == 0)
            case ($urandom_range(0, 2))
                0:       x = 6'd0;
                1:       x = 6'd47;
                default: x = 6'd63;
            endcase
        else
            x = 6'($urandom_range(0, 63));
        if ($urandom_range(0, 3) == 0)
            case ($urandom_range(0, 2))
                0:       y = 6'd0;
                1:       y = 6'd31;
                default: y = 6'd63;
            endcase
        else
            y = 6'($urandom_range(0, 63));
        write_cfg(CFG_WIDTH, w);
        write_cfg(CFG_HEIGHT, h);
        write_cfg(CFG_XPOS, x);
        write_cfg(CFG_YPOS, y);
    endtask

    task automatic host_item();
        npb_func_t op;
        op = ($urandom_range(0, 1) == 0) ? FN_READ : FN_WRITE;
        send_item(op, 9'($urandom_range(0, 511)), 16'($urandom_range(0, 65535)));
    endtask

    task automatic run_blit();
        int unsigned total, i;
        send_item(FN_START, 9'($urandom_range(0, 511)), 16'($urandom_range(0, 65535)));
        total = blit_words();
        for (i = 0; i < total; i++)
        begin
            // cut short now and then so the next start lands on a live blit
            if ($urandom_range(0, 49) == 0)
                break;
            if ($urandom_range(0, 5) == 0)
                host_item();
            if ($urandom_range(0, 39) == 0)
                drain_results();
            send_item(FN_SOURCE, 9'($urandom_range(0, 511)), 16'($urandom_range(0, 65535)));
        end
        if ($urandom_range(0, 7) == 0)
            send_item(npb_func_t'($urandom_range(0, 3)), 9'($urandom_range(0, 511)),
                      16'($urandom_range(0, 65535)));
    endtask

    always @(negedge clk)
    begin
        if (stall_left == 0 && $urandom_range(0, 99) < stall_pct)
            stall_left = $urandom_range(1, 15);
        if (stall_left != 0)
        begin
            rsp_stall <= 1'b1;
            stall_left--;
        end
        else
            rsp_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        readout_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            results_seen++;
            if (expected_readouts.size() == 0)
            begin
                $error("unexpected transfer: read_data %h blit_done %b", read_data, blit_done);
                mismatches++;
            end
            else
            begin
                want = expected_readouts.pop_front();
                if (read_data !== want.rd)
                begin
                    $error("read_data: expected %h, got %h", want.rd, read_data);
                    mismatches++;
                end
                if (blit_done !== want.done)
                begin
                    $error("blit_done: expected %b, got %b", want.done, blit_done);
                    mismatches++;
                end
                if (want.done)
                    blits_seen++;
            end
        end
    end

    initial
    begin
        int unsigned a, base_items, span;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // fill the whole store so no blit or read touches an unwritten word
        gap_pct = 5;
        stall_pct = 5;
        for (a = 0; a < STORE_WORDS; a++)
            send_item(FN_WRITE, 9'(a), 16'($urandom_range(0, 65535)));

        foreach (steps[i])
        begin
            if (steps[i].cfg)
            begin
                drain_results();
                write_cfg(steps[i].reg_idx, steps[i].reg_val);
            end
            else
                send_item(steps[i].op, steps[i].addr, steps[i].data, steps[i].typed,
                          steps[i].want_rd, steps[i].want_done);
        end

        base_items = items_sent;
        span = 0;
        while (span < RANDOM_ITEMS)
        begin
            drain_results();
            if (span + 150 > RANDOM_ITEMS)
            begin
                gap_pct = 0;
                stall_pct = 0;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       gap_pct = 0;
                    1:       gap_pct = 5;
                    2:       gap_pct = 15;
                    default: gap_pct = 35;
                endcase
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 5;
                    2:       stall_pct = 15;
                    default: stall_pct = 30;
                endcase
            end
            choose_setting();
            repeat ($urandom_range(1, 4)) run_blit();
            span = items_sent - base_items;
        end

        gap_pct = 0;
        stall_pct = 0;
        drain_results();
        $display("tb: %0d transfers in, %0d results checked, %0d blits closed",
                 items_sent, results_seen, blits_seen);
        $display("tb: %0d register writes across directed and random geometries", cfg_writes);
        if (mismatches == 0)
            $display("PASS nibble_packed_blit");
        else
            $display("FAIL nibble_packed_blit");
        $finish;
    end

endmodule
